@@ rtl/skf_pkg.sv @@
// Shared constants, types and controller codes for the scalar Kalman filter.
// No dependencies; every other source file depends on this package.
package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int GAIN_W    = FRAC_W + 1;
  localparam int MCAND_W   = DATA_W + 1;
  localparam int PROD_W    = MCAND_W + GAIN_W;
  localparam int CNT_W     = $clog2(GAIN_W);
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = DATA_W'(20 << FRAC_W);
  localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = DATA_W'(200 << FRAC_W);

  localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PM,
    ST_DEN,
    ST_DIV,
    ST_MUL,
    ST_UPD
  } skf_state_e;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic load_pm;
    logic load_den;
    logic div_start;
    logic mul_start;
    logic commit;
  } skf_ctl_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic out_free;
  } skf_sts_t;

endpackage

@@ rtl/skf_if.sv @@
// Handshake channels of the scalar Kalman filter: sample in, estimate out, config write.
// Depends on skf_pkg.
interface skf_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [skf_pkg::DATA_W-1:0]   sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_estimate_if;
  logic                                valid;
  logic                                ready;
  logic signed [skf_pkg::DATA_W-1:0]   estimate;
  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [skf_pkg::CFG_IDX_W-1:0]       index;
  logic [skf_pkg::DATA_W-1:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/skf_div.sv @@
// Bit-serial restoring divider for the gain: one quotient bit per cycle.
// Depends on skf_pkg.
module skf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skf_pkg::DATA_W-1:0]   num_i,
  input  logic [skf_pkg::DATA_W:0]     den_i,
  output logic                         done_o,
  output logic [skf_pkg::GAIN_W-1:0]   quot_o
);
  import skf_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);

  logic                busy_q, busy_d;
  logic                first_q, first_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DATA_W:0]     rem_q, rem_d;
  logic [DATA_W:0]     den_q, den_d;
  logic [GAIN_W-1:0]   quot_q, quot_d;
  logic [DATA_W+1:0]   trial;
  logic [DATA_W+1:0]   trial_sub;
  logic                ge;

  always_comb begin
    trial     = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge        = trial >= {1'b0, den_q};
    trial_sub = trial - {1'b0, den_q};
  end

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = '0;
      rem_d   = {1'b0, num_i};
      den_d   = den_i;
      quot_d  = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = ge ? trial_sub[DATA_W:0] : trial[DATA_W:0];
      quot_d  = {quot_q[GAIN_W-2:0], ge};
      cnt_d   = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/skf_mul.sv @@
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MSB first.
// Depends on skf_pkg.
module skf_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skf_pkg::MCAND_W-1:0]  a_i,
  input  logic [skf_pkg::GAIN_W-1:0]   b_i,
  output logic                         done_o,
  output logic [skf_pkg::PROD_W-1:0]   prod_o
);
  import skf_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [MCAND_W-1:0]  a_q, a_d;
  logic [GAIN_W-1:0]   b_q, b_d;
  logic [PROD_W-1:0]   acc_q, acc_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = {acc_q[PROD_W-2:0], 1'b0} + (b_q[GAIN_W-1] ? PROD_W'(a_q) : '0);
      b_d   = {b_q[GAIN_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/skf_ctrl.sv @@
// Sequencer for one filter update: predict, denominator, divide, multiply, commit.
// Depends on skf_pkg.
module skf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  skf_pkg::skf_sts_t sts_i,
  output skf_pkg::skf_ctl_t ctl_o
);
  import skf_pkg::*;

  skf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PM;
      ST_PM:   state_d = ST_DEN;
      ST_DEN:  state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_MUL;
      ST_MUL:  if (sts_i.mul_done) state_d = ST_UPD;
      ST_UPD:  if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
        ctl_o.load_in  = in_valid_i;
      end
      ST_PM: begin
        ctl_o.load_pm = 1'b1;
      end
      ST_DEN: begin
        ctl_o.load_den  = 1'b1;
        ctl_o.div_start = 1'b1;
      end
      ST_DIV: begin
        ctl_o.mul_start = sts_i.div_done;
      end
      ST_UPD: begin
        ctl_o.commit = sts_i.out_free;
      end
      default: ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/scalar_kalman_filter.sv @@
// Scalar Kalman filter (A = 1, H = 1) on signed Q16.16 samples, top level.
// Depends on skf_pkg, skf_if, skf_ctrl, skf_div and skf_mul.
//
// One sample word is taken at a time and yields one estimate word. An update
// runs from accept to the estimate on the output in these steps: the
// predicted covariance; the denominator and the innovation; the bit-serial
// gain divider (17 quotient bits, one per cycle, then done); the two
// bit-serial multipliers (17 gain bits, one per cycle, then done); then the
// commit. The next sample is taken in the idle cycle after commit, even while
// the previous estimate still waits in the output register. The process and
// measurement noise registers (index 0 and 1, unsigned Q16.16) are to be
// written by the user only while the filter is idle, which the block itself
// does not enforce; other indexes are dropped.
module scalar_kalman_filter (
  input  logic    clk_i,
  input  logic    rst_ni,
  skf_sample_if.sink     sample_in,
  skf_estimate_if.source estimate_out,
  skf_cfg_if.sink        cfg
);
  import skf_pkg::*;

  skf_ctl_t ctl;
  skf_sts_t sts;

  logic [DATA_W-1:0]        q_noise_q, r_noise_q;
  logic signed [DATA_W-1:0] est_q;
  logic [DATA_W-1:0]        cov_q;
  logic signed [DATA_W-1:0] sample_q;
  logic [DATA_W-1:0]        pm_q;
  logic                     den_zero_q;
  logic                     neg_q;
  logic [MCAND_W-1:0]       mag_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_est_q;

  logic [DATA_W:0]          pm_sum;
  logic [DATA_W:0]          den_sum;
  logic signed [DATA_W:0]   diff;
  logic [MCAND_W-1:0]       mag_d;
  logic                     div_done, mul_done, mul_cov_done;
  logic [GAIN_W-1:0]        div_quot;
  logic [GAIN_W-1:0]        gain;
  logic [GAIN_W-1:0]        gain_c;
  logic [PROD_W-1:0]        prod_corr, prod_cov;
  logic [PROD_W-FRAC_W-1:0] corr;
  logic [PROD_W-FRAC_W-1:0] cov_full;
  logic signed [DATA_W+2:0] est_ext, corr_ext, est_sum;
  logic signed [DATA_W-1:0] est_new;
  logic [DATA_W-1:0]        cov_new;

  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_in.valid),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  assign sample_in.ready = ctl.in_ready;
  assign cfg.ready       = 1'b1;

  always_comb begin
    sts.div_done = div_done;
    sts.mul_done = mul_done;
    sts.out_free = !out_valid_q || estimate_out.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= PROCESS_NOISE_RST;
      r_noise_q <= MEASUREMENT_NOISE_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PROCESS_NOISE) begin
        q_noise_q <= cfg.data;
      end else if (cfg.index == REG_MEASUREMENT_NOISE) begin
        r_noise_q <= cfg.data;
      end
    end
  end

  always_comb begin
    pm_sum  = {1'b0, cov_q} + {1'b0, q_noise_q};
    den_sum = {1'b0, pm_q} + {1'b0, r_noise_q};
    diff    = {sample_q[DATA_W-1], sample_q} - {est_q[DATA_W-1], est_q};
    mag_d   = diff[DATA_W] ? MCAND_W'(-diff) : MCAND_W'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_in) begin
      sample_q <= sample_in.sample;
    end
    if (ctl.load_pm) begin
      pm_q <= pm_sum[DATA_W] ? '1 : pm_sum[DATA_W-1:0];
    end
    if (ctl.load_den) begin
      den_zero_q <= den_sum == '0;
      neg_q      <= diff[DATA_W];
      mag_q      <= mag_d;
    end
  end

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .num_i   (pm_q),
    .den_i   (den_sum),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Div starts in the denominator cycle, right after the predicted-covariance cycle that loads pm_q.
  assign gain   = den_zero_q ? '0 : div_quot;
  assign gain_c = ONE_Q - gain;

  skf_mul u_mul_corr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     (mag_q),
    .b_i     (gain),
    .done_o  (mul_done),
    .prod_o  (prod_corr)
  );

  skf_mul u_mul_cov (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     ({1'b0, pm_q}),
    .b_i     (gain_c),
    .done_o  (mul_cov_done),
    .prod_o  (prod_cov)
  );

  always_comb begin
    corr     = prod_corr[PROD_W-1:FRAC_W];
    cov_full = prod_cov[PROD_W-1:FRAC_W];
    est_ext  = {{3{est_q[DATA_W-1]}}, est_q};
    corr_ext = {1'b0, corr};
    est_sum  = neg_q ? est_ext - corr_ext : est_ext + corr_ext;
    if (est_sum[DATA_W+2:DATA_W-1] == '0 || est_sum[DATA_W+2:DATA_W-1] == '1) begin
      est_new = est_sum[DATA_W-1:0];
    end else if (est_sum[DATA_W+2]) begin
      est_new = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      est_new = {1'b0, {(DATA_W-1){1'b1}}};
    end
    cov_new = (|cov_full[PROD_W-FRAC_W-1:DATA_W]) ? '1 : cov_full[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= '0;
      cov_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl.commit) begin
        est_q       <= est_new;
        cov_q       <= cov_new;
        out_valid_q <= 1'b1;
      end else if (estimate_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      out_est_q <= est_new;
    end
  end

  assign estimate_out.valid    = out_valid_q;
  assign estimate_out.estimate = out_est_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
    else $error("sample taken while an update is in progress");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.mul_start |-> gain <= ONE_Q)
    else $error("gain above one");

  a_mul_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done == mul_cov_done)
    else $error("multipliers out of step");

  a_cov_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> cov_q <= $past(pm_q))
    else $error("covariance grew past the prediction");

endmodule

@@ verif/tb.sv @@
// Testbench for scalar_kalman_filter: random and directed samples under random
// handshake stalls, checked word by word against an in-bench fixed-point predictor.
// Depends on skf_pkg, the skf_if interfaces and the RTL of the filter.
`timescale 1ns / 100ps

module tb;
  import skf_pkg::*;

  localparam longint          EST_MAX    = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint          EST_MIN    = -EST_MAX - 1;
  localparam longint unsigned COV_MAX    = (64'd1 << DATA_W) - 1;
  localparam longint unsigned GAIN_ONE   = 64'd1 << FRAC_W;
  localparam logic [DATA_W-1:0] NOISE_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MEASUREMENT_NOISE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 60;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_e;

  class kf_scoreboard;
    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;
    logic signed [DATA_W-1:0] est;
    logic [DATA_W-1:0]        cov;
    logic signed [DATA_W-1:0] estimates_due[$];
    int                       errors;

    function new();
      q_noise = PROCESS_NOISE_RST;
      r_noise = MEASUREMENT_NOISE_RST;
      est     = '0;
      cov     = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == REG_PROCESS_NOISE) begin
        q_noise = val;
      end else if (idx == REG_MEASUREMENT_NOISE) begin
        r_noise = val;
      end
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] z);
      longint unsigned pm, den, gain, mag, corr, pnew;
      longint          diff, xnew;
      pm = 64'(cov) + 64'(q_noise);
      if (pm > COV_MAX) begin
        pm = COV_MAX;
      end
      den  = pm + 64'(r_noise);
      gain = (den == 0) ? 64'd0 : (pm << FRAC_W) / den;
      diff = longint'(z) - longint'(est);
      mag  = (diff < 0) ? longint'(-diff) : diff;
      corr = (mag * gain) >> FRAC_W;
      xnew = (diff < 0) ? longint'(est) - longint'(corr) : longint'(est) + longint'(corr);
      if (xnew > EST_MAX) begin
        xnew = EST_MAX;
      end
      if (xnew < EST_MIN) begin
        xnew = EST_MIN;
      end
      pnew = (pm * (GAIN_ONE - gain)) >> FRAC_W;
      if (pnew > COV_MAX) begin
        pnew = COV_MAX;
      end
      est = xnew[DATA_W-1:0];
      cov = pnew[DATA_W-1:0];
      estimates_due.push_back(est);
    endfunction

    function void check_estimate(logic signed [DATA_W-1:0] act);
      logic signed [DATA_W-1:0] want;
      if (estimates_due.size() == 0) begin
        $display("%0t: estimate expected none, got %0d", $time, act);
        errors++;
        return;
      end
      want = estimates_due.pop_front();
      if (act !== want) begin
        $display("%0t: estimate expected %0d, got %0d", $time, want, act);
        errors++;
      end
    endfunction

    function int pending();
      return estimates_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  skf_sample_if   s_if ();
  skf_estimate_if e_if ();
  skf_cfg_if      c_if ();

  scalar_kalman_filter dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .sample_in    (s_if),
    .estimate_out (e_if),
    .cfg          (c_if)
  );

  kf_scoreboard sb = new();

  int       burst_left = 0;
  int       level      = 0;
  int       noise_amp  = 1 << FRAC_W;
  int       idle_cycles = 0;
  bit       hold_req   = 1'b0;
  bit       hold_done  = 1'b0;
  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  logic [31:0] rx_pattern = '1;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && s_if.valid && s_if.ready) begin
      sb.note_sample(s_if.sample);
    end
    if (rst_n && c_if.valid && c_if.ready) begin
      sb.write_reg(c_if.index, c_if.data);
    end
    if (rst_n && e_if.valid && e_if.ready) begin
      sb.check_estimate(e_if.estimate);
    end
  end

  always @(posedge clk) begin
    if ((s_if.valid && s_if.ready) || (c_if.valid && c_if.ready) ||
        (e_if.valid && e_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rx_mode   = RX_HOLD;
        rx_left   = HOLD_CYCLES;
      end else begin
        rx_mode    = rx_mode_e'($urandom_range(0, 2));
        rx_left    = $urandom_range(16, 256);
        rx_pattern = $urandom | 32'h1;
      end
    end
    case (rx_mode)
      RX_OPEN:    e_if.ready <= 1'b1;
      RX_RANDOM:  e_if.ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: e_if.ready <= rx_pattern[rx_left % 32];
      default:    e_if.ready <= 1'b0;
    endcase
    rx_left--;
  end

  task automatic send_sample(input logic [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_if.valid  <= 1'b1;
    s_if.sample <= v;
    @(posedge clk);
    while (!s_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    c_if.valid <= 1'b1;
    c_if.index <= idx;
    c_if.data  <= val;
    @(posedge clk);
    while (!c_if.ready) @(posedge clk);
  endtask

  // drain every outstanding estimate, optionally write an unused index, then write both noise registers
  task automatic configure(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                           input bit stray);
    s_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
    end
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    c_if.valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return NOISE_MAX;
      2:       return DATA_W'($urandom_range(0, 16 << FRAC_W));
      3:       return DATA_W'($urandom_range(1 << FRAC_W, 1000 << FRAC_W));
      default: return $urandom;
    endcase
  endfunction

  // mostly a drifting level with bounded noise, plus raw words and extremes
  function automatic logic [DATA_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      return $urandom;
    end
    if (pick == 2) begin
      case ($urandom_range(0, 4))
        0:       return {1'b0, {(DATA_W-1){1'b1}}};
        1:       return {1'b1, {(DATA_W-1){1'b0}}};
        2:       return '0;
        3:       return '1;
        default: return DATA_W'(1);
      endcase
    end
    if ($urandom_range(0, 39) == 0) begin
      level = int'($urandom_range(0, 32000 << FRAC_W)) - (16000 << FRAC_W);
    end else begin
      level += int'($urandom_range(0, 2 << FRAC_W)) - (1 << FRAC_W);
      if (level > (16000 << FRAC_W) || level < -(16000 << FRAC_W)) begin
        level = 0;
      end
    end
    return DATA_W'(level + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
  endfunction

  initial begin
    rst_n       = 1'b0;
    s_if.valid  <= 1'b0;
    s_if.sample <= '0;
    c_if.valid  <= 1'b0;
    c_if.index  <= REG_PROCESS_NOISE;
    c_if.data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero denominator: estimate and covariance hold at zero
    configure('0, '0, 1'b0);
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample({1'b1, {(DATA_W-1){1'b0}}});
    send_sample(DATA_W'(1));

    // unit gain: estimate tracks the sample exactly
    configure(NOISE_MAX, '0, 1'b0);
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample({1'b1, {(DATA_W-1){1'b0}}});
    send_sample('1);
    send_sample('0);
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample({1'b1, {(DATA_W-1){1'b0}}});

    // saturating predicted covariance with full-scale swings
    configure(NOISE_MAX, NOISE_MAX, 1'b0);
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample({1'b1, {(DATA_W-1){1'b0}}});
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample({1'b1, {(DATA_W-1){1'b0}}});

    configure('0, NOISE_MAX, 1'b0);
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample('1);
    send_sample(DATA_W'(1));

    configure(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST, 1'b1);
    send_sample(DATA_W'(1));
    send_sample('1);
    send_sample(DATA_W'(1 << FRAC_W));
    send_sample(DATA_W'(-(100 << FRAC_W)));
    send_sample(DATA_W'(100 << FRAC_W));

    for (int ph = 0; ph < 6; ph++) begin
      configure(pick_noise(), pick_noise(), $urandom_range(0, 1));
      level     = 0;
      noise_amp = $urandom_range(1 << 12, 50 << FRAC_W);
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      repeat (300) send_sample(next_sample());
    end

    s_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/skf_pkg.sv
rtl/skf_if.sv
rtl/skf_div.sv
rtl/skf_mul.sv
rtl/skf_ctrl.sv
rtl/scalar_kalman_filter.sv
verif/tb.sv
